[src/skfq_pkg.sv]
// Package: shared types and constants for the sorted key frequency table.
`default_nettype none
package skfq_pkg;

	localparam int KEY_W      = 64;
	localparam int COUNT_W    = 16;
	localparam int FRAC_BITS  = 16;
	localparam int FRAC_W     = FRAC_BITS + 1;
	localparam int DIVIDEND_W = COUNT_W + FRAC_BITS;

	localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
	localparam logic [15:0]        MAX_PTS_RESET = 16'd1024;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_EMIT  = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam logic REG_MAX_POINTS = 1'b0;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [KEY_W-1:0]  key;
	} req_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_out;
		logic [FRAC_W-1:0] fraction;
		logic              end_marker;
		logic              empty_res;
		logic              last;
		logic              full_res;
		logic [15:0]       point_count;
		logic              overflow;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [COUNT_W-1:0] count;
	} entry_t;

endpackage
`default_nettype wire

[src/skfq_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module skfq_ram #(
	parameter int WIDTH = 80,
	parameter int DEPTH = 32,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

[src/skfq_div.sv]
// Restoring divider: one quotient bit per cycle for the normalized fraction.
`default_nettype none
module skfq_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [skfq_pkg::DIVIDEND_W-1:0]  dividend,
	input  wire logic [skfq_pkg::COUNT_W-1:0]     divisor,
	output logic                                  done,
	output logic      [skfq_pkg::DIVIDEND_W-1:0]  quotient
);

	localparam int NW = skfq_pkg::DIVIDEND_W;
	localparam int DW = skfq_pkg::COUNT_W;
	localparam int CNT_W = $clog2(NW + 1);

	logic [DW-1:0]    rem_q;
	logic [NW-1:0]    quo_q;
	logic [DW-1:0]    div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DW:0]      trial;
	logic [DW:0]      diff;
	logic             take;

	assign trial = {rem_q, quo_q[NW-1]};
	assign diff  = trial - {1'b0, div_q};
	assign take  = (trial >= {1'b0, div_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= take ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], take};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	property p_no_restart;
		@(posedge clk) disable iff (!arst_n) busy_q |-> !start;
	endproperty
	a_no_restart: assert property (p_no_restart) else $error("divider restarted while busy");

	property p_done_ends_busy;
		@(posedge clk) disable iff (!arst_n) done_q |-> !busy_q && $past(busy_q);
	endproperty
	a_done_ends_busy: assert property (p_done_ends_busy) else $error("done without busy run");

	property p_count_bounded;
		@(posedge clk) disable iff (!arst_n) cnt_q <= CNT_W'(NW);
	endproperty
	a_count_bounded: assert property (p_count_bounded) else $error("step count out of range");

endmodule
`default_nettype wire

[src/sorted_key_frequency_table.sv]
// Top level: sorted key frequency table with a sequencer over one entry RAM.
// The table keeps up to TABLE_DEPTH distinct 64-bit keys in ascending order in
// one synchronous RAM (one write port, one registered read port). An add word
// searches upward from entry 0, reading and then comparing each entry visited;
// a hit raises the count in place (saturating at 65535), a new key shifts every
// larger entry up one slot (a read of the entry below, then a write) and is
// written at its place with count 1; if the table is already full the key is
// dropped and overflow is set, but the point still counts toward the total. An
// emit word reads each entry in turn and divides count * 2^16 by the total in
// a one-bit-per-cycle divider, giving one result word per entry, then one
// terminator word; an empty table gives a single word with empty_res set. A
// clear word resets the entry count and total as it answers with one status
// word. Command code 3 is taken and ignored. A new request word is taken only
// while the sequencer is idle; one output register holds a finished result
// word, so the next request can enter while the previous result still waits
// for rsp_ready. max_points sits at byte address 0 of the APB port (reset
// 1024); write it only while the block is idle. No clearing pass is needed
// after reset.
`default_nettype none
module sorted_key_frequency_table #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// request channel
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire skfq_pkg::req_t    req,
	// result channel
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output skfq_pkg::rsp_t         rsp,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);
	localparam int EW = $bits(skfq_pkg::entry_t);

	typedef enum logic [13:0] {
		ST_IDLE = 14'b00000000000001,
		ST_ARD  = 14'b00000000000010,
		ST_ACMP = 14'b00000000000100,
		ST_SRD  = 14'b00000000001000,
		ST_SWR  = 14'b00000000010000,
		ST_INS  = 14'b00000000100000,
		ST_ARSP = 14'b00000001000000,
		ST_ERD  = 14'b00000010000000,
		ST_ELD  = 14'b00000100000000,
		ST_EDIV = 14'b00001000000000,
		ST_EOUT = 14'b00010000000000,
		ST_EEND = 14'b00100000000000,
		ST_EEMP = 14'b01000000000000,
		ST_CRSP = 14'b10000000000000
	} state_t;

	state_t                          state_q;
	logic [CW-1:0]                   used_q;
	logic [15:0]                     total_q;
	logic [15:0]                     max_q;
	logic [CW-1:0]                   idx_q;
	logic [CW-1:0]                   pos_q;
	logic [skfq_pkg::KEY_W-1:0]      key_q;
	logic                            ovf_q;
	skfq_pkg::rsp_t                  rsp_q;
	logic                            rsp_valid_q;

	// RAM side
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	skfq_pkg::entry_t                ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [EW-1:0]                   ram_rdata_raw;
	skfq_pkg::entry_t                ram_rdata;

	// divider side
	logic                            div_start;
	logic                            div_done;
	logic [skfq_pkg::DIVIDEND_W-1:0] div_q;

	logic [CW-1:0]                   idx_m1;
	logic [CW-1:0]                   idx_p1;
	logic [15:0]                     total_nx;
	logic [skfq_pkg::COUNT_W-1:0]    count_inc;
	logic                            slot_free;
	logic                            push;
	logic                            key_hit;
	logic                            key_above;
	logic                            cfg_wr;

	assign idx_m1    = idx_q - 1'b1;
	assign idx_p1    = idx_q + 1'b1;
	assign total_nx  = (total_q == 16'hFFFF) ? total_q : total_q + 1'b1;
	assign count_inc = (ram_rdata.count == skfq_pkg::COUNT_MAX) ?
	                   ram_rdata.count : ram_rdata.count + 1'b1;
	assign ram_rdata = skfq_pkg::entry_t'(ram_rdata_raw);
	assign key_hit   = (ram_rdata.key == key_q);
	assign key_above = (ram_rdata.key > key_q);
	assign slot_free = !rsp_valid_q || rsp_ready;
	assign push      = slot_free && (state_q == ST_ARSP || state_q == ST_EOUT ||
	                   state_q == ST_EEND || state_q == ST_EEMP || state_q == ST_CRSP);

	assign req_ready = (state_q == ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// APB: single register, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == skfq_pkg::REG_MAX_POINTS) ? {16'd0, max_q} : 32'd0;

	// RAM port steering: shift reads fetch the entry just below the slot being filled
	always_comb begin
		ram_raddr = (state_q == ST_SRD) ? idx_m1[AW-1:0] : idx_q[AW-1:0];
		ram_we    = 1'b0;
		ram_waddr = idx_q[AW-1:0];
		ram_wdata = ram_rdata;
		case (state_q)
			ST_ACMP: begin
				ram_we    = key_hit;
				ram_wdata = '{key: key_q, count: count_inc};
			end
			ST_SWR: begin
				ram_we = 1'b1;
			end
			ST_INS: begin
				ram_we    = 1'b1;
				ram_waddr = pos_q[AW-1:0];
				ram_wdata = '{key: key_q, count: skfq_pkg::COUNT_W'(1)};
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	assign div_start = (state_q == ST_ELD);

	skfq_ram #(
		.WIDTH (EW),
		.DEPTH (TABLE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata_raw)
	);

	skfq_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({ram_rdata.count, skfq_pkg::FRAC_BITS'(0)}),
		.divisor  (total_q),
		.done     (div_done),
		.quotient (div_q)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= skfq_pkg::MAX_PTS_RESET;
		end else if (cfg_wr && paddr[2] == skfq_pkg::REG_MAX_POINTS) begin
			max_q <= pwdata[15:0];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			total_q     <= '0;
			idx_q       <= '0;
			pos_q       <= '0;
			ovf_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (push) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						ovf_q <= 1'b0;
						idx_q <= '0;
						case (skfq_pkg::cmd_t'(req.cmd))
							skfq_pkg::CMD_ADD: begin
								if (used_q == '0) begin
									pos_q   <= '0;
									state_q <= ST_INS;
								end else begin
									state_q <= ST_ARD;
								end
							end
							skfq_pkg::CMD_EMIT: begin
								state_q <= (used_q == '0) ? ST_EEMP : ST_ERD;
							end
							skfq_pkg::CMD_CLEAR: begin
								state_q <= ST_CRSP;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_ARD: begin
					state_q <= ST_ACMP;
				end
				ST_ACMP: begin
					if (key_hit) begin
						state_q <= ST_ARSP;
					end else if (key_above) begin
						pos_q <= idx_q;
						if (used_q == DEPTH_C) begin
							ovf_q   <= 1'b1;
							state_q <= ST_ARSP;
						end else begin
							idx_q   <= used_q;
							state_q <= ST_SRD;
						end
					end else if (idx_p1 == used_q) begin
						pos_q <= used_q;
						if (used_q == DEPTH_C) begin
							ovf_q   <= 1'b1;
							state_q <= ST_ARSP;
						end else begin
							state_q <= ST_INS;
						end
					end else begin
						idx_q   <= idx_p1;
						state_q <= ST_ARD;
					end
				end
				ST_SRD: begin
					state_q <= ST_SWR;
				end
				ST_SWR: begin
					// entry idx-1 now sits at idx; step down
					idx_q   <= idx_m1;
					state_q <= (idx_m1 == pos_q) ? ST_INS : ST_SRD;
				end
				ST_INS: begin
					used_q  <= used_q + 1'b1;
					state_q <= ST_ARSP;
				end
				ST_ARSP: begin
					if (slot_free) begin
						total_q <= total_nx;
						state_q <= ST_IDLE;
					end
				end
				ST_ERD: begin
					state_q <= ST_ELD;
				end
				ST_ELD: begin
					state_q <= ST_EDIV;
				end
				ST_EDIV: begin
					if (div_done) begin
						state_q <= ST_EOUT;
					end
				end
				ST_EOUT: begin
					if (slot_free) begin
						idx_q   <= idx_p1;
						state_q <= (idx_p1 == used_q) ? ST_EEND : ST_ERD;
					end
				end
				ST_EEND, ST_EEMP: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_CRSP: begin
					if (slot_free) begin
						used_q  <= '0;
						total_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload: capture the key on accept and on each entry load
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && req_valid) begin
			key_q <= req.key;
		end else if (state_q == ST_ELD) begin
			key_q <= ram_rdata.key;
		end
	end

	// result word builder
	always_ff @(posedge clk) begin
		if (push) begin
			rsp_q.key_out     <= '0;
			rsp_q.fraction    <= '0;
			rsp_q.end_marker  <= 1'b0;
			rsp_q.empty_res   <= 1'b0;
			rsp_q.last        <= 1'b1;
			rsp_q.full_res    <= (total_q >= max_q);
			rsp_q.point_count <= total_q;
			rsp_q.overflow    <= 1'b0;
			case (state_q)
				ST_ARSP: begin
					rsp_q.key_out     <= key_q;
					rsp_q.full_res    <= (total_nx >= max_q);
					rsp_q.point_count <= total_nx;
					rsp_q.overflow    <= ovf_q;
				end
				ST_EOUT: begin
					rsp_q.key_out  <= key_q;
					rsp_q.fraction <= (total_q == '0) ? '0 : div_q[skfq_pkg::FRAC_W-1:0];
					rsp_q.last     <= 1'b0;
				end
				ST_EEND: begin
					rsp_q.end_marker <= 1'b1;
				end
				ST_EEMP: begin
					rsp_q.empty_res <= 1'b1;
				end
				ST_CRSP: begin
					rsp_q.full_res    <= (max_q == '0);
					rsp_q.point_count <= '0;
				end
				default: begin
					rsp_q.last <= 1'b1;
				end
			endcase
		end
	end

	property p_used_bounded;
		@(posedge clk) disable iff (!arst_n) used_q <= DEPTH_C;
	endproperty
	a_used_bounded: assert property (p_used_bounded) else $error("entry count past depth");

	property p_no_write_idle;
		@(posedge clk) disable iff (!arst_n) (state_q == ST_IDLE) |-> !ram_we;
	endproperty
	a_no_write_idle: assert property (p_no_write_idle) else $error("RAM written while idle");

	property p_clear_empties;
		@(posedge clk) disable iff (!arst_n)
			(state_q == ST_CRSP && slot_free) |=> (used_q == '0 && total_q == '0);
	endproperty
	a_clear_empties: assert property (p_clear_empties) else $error("clear left entries");

	property p_push_needs_slot;
		@(posedge clk) disable iff (!arst_n) (rsp_valid_q && !rsp_ready) |-> !push;
	endproperty
	a_push_needs_slot: assert property (p_push_needs_slot) else $error("result overwritten");

endmodule
`default_nettype wire
